@@ hdl/mzrb_pkg.sv @@
// Package for the MTF / zero-run bucket decoder.
// Holds shared widths, operation and status codes, and the MTF list command word.
// No dependencies.
`default_nettype none

package mzrb_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SYM_W   = 9;
  localparam int unsigned REP_W   = 22;
  localparam int unsigned LEN_W   = 21;
  localparam int unsigned ASIZE_W = 9;
  localparam int unsigned STAT_W  = 3;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0]   BUCKET_LENGTH_RST = 21'd1048576;
  localparam logic [ASIZE_W-1:0] ALPHABET_SIZE_RST = 9'd256;

  // Symbol codes for zero-rank runs
  localparam logic [SYM_W-1:0] SYM_RUNA = 9'd0;
  localparam logic [SYM_W-1:0] SYM_RUNB = 9'd1;

  // Configuration register indexes
  localparam logic REG_BUCKET_LENGTH = 1'b0;
  localparam logic REG_ALPHABET_SIZE = 1'b1;

  // Input word operation codes
  typedef enum logic [1:0] {
    OP_MAP  = 2'd0,
    OP_MTF  = 2'd1,
    OP_SYM  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_DONE      = 3'd1,
    ST_OVERRUN   = 3'd2,
    ST_EARLY_END = 3'd3,
    ST_BAD_RANK  = 3'd4
  } status_e;

  // Command to the row of MTF cells
  typedef struct packed {
    logic load;  // write load data into the selected cell
    logic move;  // move selected entry to front, shift the ones above it down
  } mtf_cmd_t;

endpackage

`default_nettype wire

@@ hdl/mzrb_cell.sv @@
// One cell of the MTF list: holds a single entry, loads it or takes its neighbor's.
// Depends on mzrb_pkg.
`default_nettype none

module mzrb_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 8
) (
  input  wire logic                                 clk_i,
  input  wire mzrb_pkg::mtf_cmd_t                   cmd_i,
  input  wire logic [IDX_W-1:0]                     sel_i,
  input  wire logic [mzrb_pkg::BYTE_W-1:0]          load_data_i,
  input  wire logic [mzrb_pkg::BYTE_W-1:0]          left_i,
  output logic      [mzrb_pkg::BYTE_W-1:0]          entry_o,
  output logic      [mzrb_pkg::BYTE_W-1:0]          tap_o
);

  logic [mzrb_pkg::BYTE_W-1:0] entry_q;
  logic                        hit;
  logic                        in_move;

  assign hit     = (sel_i == IDX_W'(INDEX));
  assign in_move = (sel_i >= IDX_W'(INDEX));

  // Entry register: load, or shift down from the left neighbor on a move
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && hit) begin
      entry_q <= load_data_i;
    end else if (cmd_i.move && in_move) begin
      entry_q <= left_i;
    end
  end

  assign entry_o = entry_q;
  // Only the selected cell drives its tap
  assign tap_o   = hit ? entry_q : '0;

endmodule

`default_nettype wire

@@ hdl/mzrb_mtf_list.sv @@
// Move-to-front list built as a row of mzrb_cell, plus the OR tree that picks an entry.
// Depends on mzrb_pkg and mzrb_cell.
`default_nettype none

module mzrb_mtf_list #(
  parameter int unsigned ALPHABET = 256,
  parameter int unsigned IDX_W    = 8
) (
  input  wire logic                        clk_i,
  input  wire mzrb_pkg::mtf_cmd_t          cmd_i,
  input  wire logic [IDX_W-1:0]            sel_i,
  input  wire logic [mzrb_pkg::BYTE_W-1:0] load_data_i,
  output logic      [mzrb_pkg::BYTE_W-1:0] picked_o
);

  logic [mzrb_pkg::BYTE_W-1:0] entry_w [ALPHABET];
  logic [mzrb_pkg::BYTE_W-1:0] tap_w   [ALPHABET];
  logic [ALPHABET-1:0]         col_w   [mzrb_pkg::BYTE_W];

  // Row of cells; the front cell takes the picked entry on a move
  for (genvar i = 0; i < ALPHABET; i++) begin : g_cell
    logic [mzrb_pkg::BYTE_W-1:0] left;
    if (i == 0) begin : g_front
      assign left = picked_o;
    end else begin : g_rest
      assign left = entry_w[i-1];
    end

    mzrb_cell #(
      .INDEX(i),
      .IDX_W(IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i),
      .sel_i      (sel_i),
      .load_data_i(load_data_i),
      .left_i     (left),
      .entry_o    (entry_w[i]),
      .tap_o      (tap_w[i])
    );

    for (genvar b = 0; b < mzrb_pkg::BYTE_W; b++) begin : g_bit
      assign col_w[b][i] = tap_w[i][b];
    end
  end

  // OR tree over the one-hot taps
  for (genvar b = 0; b < mzrb_pkg::BYTE_W; b++) begin : g_or
    assign picked_o[b] = |col_w[b];
  end

endmodule

`default_nettype wire

@@ hdl/mzrb_inv_map.sv @@
// Inverse alphabet map: local code to byte, one write port and one registered read.
// Depends on mzrb_pkg.
`default_nettype none

module mzrb_inv_map #(
  parameter int unsigned ALPHABET = 256,
  parameter int unsigned IDX_W    = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [IDX_W-1:0]            waddr_i,
  input  wire logic [mzrb_pkg::BYTE_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [IDX_W-1:0]            raddr_i,
  output logic      [mzrb_pkg::BYTE_W-1:0] rdata_o
);

  logic [mzrb_pkg::BYTE_W-1:0] mem [ALPHABET];
  logic [mzrb_pkg::BYTE_W-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/mtf_zero_run_bucket_decoder.sv @@
// MTF / zero-run bucket decoder, top level.
// Load words (map bit, MTF entry) are taken one per cycle while the input is not stalled.
// End and bad-rank symbols: result is in the output register in the cycle after accept.
// Run and rank symbols: the pick from the cell row feeds the registered inverse-map read,
// then the pending result moves into the output register; no new word is taken meanwhile.
// Reset clears counters, flags and config to 1048576 / 256; list and map are not cleared.
`default_nettype none

module mtf_zero_run_bucket_decoder #(
  parameter int unsigned ALPHABET    = 256,
  parameter int unsigned LENGTH_BITS = 20
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input words
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [1:0]                           operation_i,
  input  wire logic                                 map_bit_i,
  input  wire logic [mzrb_pkg::BYTE_W-1:0]          mtf_entry_i,
  input  wire logic [mzrb_pkg::SYM_W-1:0]           symbol_i,
  // result words
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic      [mzrb_pkg::BYTE_W-1:0]          byte_value_o,
  output logic      [mzrb_pkg::REP_W-1:0]           repeat_count_o,
  output logic      [mzrb_pkg::STAT_W-1:0]          status_o,
  // configuration writes
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic                                 cfg_index_i,
  input  wire logic [mzrb_pkg::LEN_W-1:0]           cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(ALPHABET);
  localparam int unsigned CNT_W = $clog2(ALPHABET + 1);
  localparam int unsigned ACC_W = 35;
  localparam logic [ACC_W-1:0] REPEAT_MAX = ACC_W'(2) << LENGTH_BITS;

  // Configuration
  logic [mzrb_pkg::LEN_W-1:0]   bucket_len_q;
  logic [mzrb_pkg::ASIZE_W-1:0] alpha_size_q;

  // Control state
  logic [CNT_W-1:0]           local_size_q, local_size_d;
  logic [CNT_W-1:0]           map_pos_q, map_pos_d;
  logic [CNT_W-1:0]           load_pos_q, load_pos_d;
  logic [4:0]                 run_pos_q, run_pos_d;
  logic [mzrb_pkg::LEN_W-1:0] bytes_q, bytes_d;
  logic                       finished_q, finished_d;
  logic                       pend_q, pend_d;

  // Pending result (waits for the inverse-map read)
  logic [mzrb_pkg::REP_W-1:0]  pend_cnt_q, pend_cnt_d;
  mzrb_pkg::status_e           pend_st_q, pend_st_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic [mzrb_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic [mzrb_pkg::REP_W-1:0]  out_cnt_q, out_cnt_d;
  mzrb_pkg::status_e           out_st_q, out_st_d;

  // Datapath signals
  logic                        in_accept;
  logic                        out_free;
  logic                        map_room, ls_room, load_room;
  logic                        is_end, is_run, bad_rank;
  logic [mzrb_pkg::SYM_W-1:0]  rank;
  logic [ACC_W-1:0]            count, total, sat_count;
  logic                        over, exact;
  logic                        stop_go, emit_go;
  mzrb_pkg::status_e           stop_st;
  mzrb_pkg::mtf_cmd_t          mtf_cmd;
  logic [IDX_W-1:0]            mtf_sel;
  logic [mzrb_pkg::BYTE_W-1:0] picked;
  logic                        map_we;
  logic [mzrb_pkg::BYTE_W-1:0] map_rdata;

  // Handshakes
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = pend_q || (out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Bounds checks for the load words
  assign map_room  = (10'(map_pos_q) < 10'(alpha_size_q)) && (map_pos_q < CNT_W'(ALPHABET));
  assign ls_room   = (local_size_q < CNT_W'(ALPHABET));
  assign load_room = (load_pos_q < local_size_q) && (load_pos_q < CNT_W'(ALPHABET));

  // Symbol classification
  assign is_end   = (10'(symbol_i) == 10'(local_size_q) + 10'd1);
  assign is_run   = (symbol_i == mzrb_pkg::SYM_RUNA) || (symbol_i == mzrb_pkg::SYM_RUNB);
  assign rank     = symbol_i - mzrb_pkg::SYM_W'(1);
  assign bad_rank = (10'(rank) >= 10'(local_size_q));

  // Run length or single byte, then the length bookkeeping
  assign count = is_run ? ((symbol_i == mzrb_pkg::SYM_RUNA) ? ACC_W'(1) : ACC_W'(2)) << run_pos_q
                        : ACC_W'(1);
  assign total     = ACC_W'(bytes_q) + count;
  assign over      = total > ACC_W'(bucket_len_q);
  assign exact     = total == ACC_W'(bucket_len_q);
  assign sat_count = (over && (count > REPEAT_MAX)) ? REPEAT_MAX : count;

  // Decode of the accepted word
  always_comb begin
    local_size_d = local_size_q;
    map_pos_d    = map_pos_q;
    load_pos_d   = load_pos_q;
    run_pos_d    = run_pos_q;
    bytes_d      = bytes_q;
    finished_d   = finished_q;
    pend_cnt_d   = pend_cnt_q;
    pend_st_d    = pend_st_q;
    map_we       = 1'b0;
    mtf_cmd      = '0;
    mtf_sel      = load_pos_q[IDX_W-1:0];
    stop_go      = 1'b0;
    stop_st      = mzrb_pkg::ST_BAD_RANK;
    emit_go      = 1'b0;

    if (in_accept) begin
      case (operation_i)
        mzrb_pkg::OP_MAP: begin
          if (map_room) begin
            map_pos_d = map_pos_q + CNT_W'(1);
            if (map_bit_i && ls_room) begin
              map_we       = 1'b1;
              local_size_d = local_size_q + CNT_W'(1);
            end
          end
        end
        mzrb_pkg::OP_MTF: begin
          if (load_room) begin
            mtf_cmd.load = 1'b1;
            load_pos_d   = load_pos_q + CNT_W'(1);
          end
        end
        mzrb_pkg::OP_SYM: begin
          if (!finished_q) begin
            if (is_end) begin
              stop_go    = 1'b1;
              stop_st    = (ACC_W'(bytes_q) == ACC_W'(bucket_len_q)) ? mzrb_pkg::ST_DONE
                                                                    : mzrb_pkg::ST_EARLY_END;
              finished_d = 1'b1;
              run_pos_d  = '0;
            end else if (!is_run && bad_rank) begin
              stop_go    = 1'b1;
              stop_st    = mzrb_pkg::ST_BAD_RANK;
              finished_d = 1'b1;
              run_pos_d  = '0;
            end else begin
              emit_go = 1'b1;
              if (is_run) begin
                mtf_sel = '0;
                if (run_pos_q != 5'd31) begin
                  run_pos_d = run_pos_q + 5'd1;
                end
              end else begin
                mtf_sel      = rank[IDX_W-1:0];
                mtf_cmd.move = 1'b1;
                run_pos_d    = '0;
              end
              pend_cnt_d = sat_count[mzrb_pkg::REP_W-1:0];
              if (over) begin
                finished_d = 1'b1;
                pend_st_d  = mzrb_pkg::ST_OVERRUN;
              end else begin
                bytes_d = total[mzrb_pkg::LEN_W-1:0];
                if (exact) begin
                  finished_d = 1'b1;
                  pend_st_d  = mzrb_pkg::ST_DONE;
                end else begin
                  pend_st_d  = mzrb_pkg::ST_OK;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pending flag: set on an emit, cleared when the result moves out
  always_comb begin
    pend_d = pend_q;
    if (emit_go) begin
      pend_d = 1'b1;
    end else if (pend_q && out_free) begin
      pend_d = 1'b0;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    if (stop_go) begin
      out_valid_d = 1'b1;
      out_byte_d  = '0;
      out_cnt_d   = '0;
      out_st_d    = stop_st;
    end else if (pend_q && out_free) begin
      out_valid_d = 1'b1;
      out_byte_d  = map_rdata;
      out_cnt_d   = pend_cnt_q;
      out_st_d    = pend_st_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_len_q <= mzrb_pkg::BUCKET_LENGTH_RST;
      alpha_size_q <= mzrb_pkg::ALPHABET_SIZE_RST;
      local_size_q <= '0;
      map_pos_q    <= '0;
      load_pos_q   <= '0;
      run_pos_q    <= '0;
      bytes_q      <= '0;
      finished_q   <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == mzrb_pkg::REG_BUCKET_LENGTH) begin
          bucket_len_q <= cfg_data_i;
        end else begin
          alpha_size_q <= cfg_data_i[mzrb_pkg::ASIZE_W-1:0];
        end
      end
      local_size_q <= local_size_d;
      map_pos_q    <= map_pos_d;
      load_pos_q   <= load_pos_d;
      run_pos_q    <= run_pos_d;
      bytes_q      <= bytes_d;
      finished_q   <= finished_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_cnt_q <= pend_cnt_d;
    pend_st_q  <= pend_st_d;
    out_byte_q <= out_byte_d;
    out_cnt_q  <= out_cnt_d;
    out_st_q   <= out_st_d;
  end

  // MTF list
  mzrb_mtf_list #(
    .ALPHABET(ALPHABET),
    .IDX_W   (IDX_W)
  ) u_mtf_list (
    .clk_i      (clk_i),
    .cmd_i      (mtf_cmd),
    .sel_i      (mtf_sel),
    .load_data_i(mtf_entry_i),
    .picked_o   (picked)
  );

  // Inverse alphabet map
  mzrb_inv_map #(
    .ALPHABET(ALPHABET),
    .IDX_W   (IDX_W)
  ) u_inv_map (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(local_size_q[IDX_W-1:0]),
    .wdata_i(mzrb_pkg::BYTE_W'(map_pos_q)),
    .re_i   (emit_go),
    .raddr_i(picked[IDX_W-1:0]),
    .rdata_o(map_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign byte_value_o   = out_byte_q;
  assign repeat_count_o = out_cnt_q;
  assign status_o       = out_st_q;

  // A pending result blocks new words
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> in_stall_o)
    else $error("word accepted while a result is pending");

  // A pending result reaches the output once the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (pend_q && out_free) |=> (out_valid_q && !pend_q))
    else $error("pending result lost");

  // Finished stays set until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) finished_q |=> finished_q)
    else $error("finished flag dropped");

  // Local alphabet never exceeds the cell count
  assert property (@(posedge clk_i) disable iff (!rst_ni) local_size_q <= CNT_W'(ALPHABET))
    else $error("local alphabet size out of range");

  // A successful result never leaves the byte count past the bucket length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (emit_go && !over) |=> (bytes_q <= bucket_len_q))
    else $error("byte count passed bucket length");

endmodule

`default_nettype wire

@@ tb/mtf_zero_run_bucket_decoder_test.sv @@
// Self-checking bench for the MTF / zero-run bucket decoder.
// It loads the presence map and MTF list, then sends directed and random symbol words.
// Each result word is checked against an in-bench decoder. Depends on hdl/mzrb_pkg.sv.
`timescale 1ns / 100ps

module mtf_zero_run_bucket_decoder_test;
  import mzrb_pkg::*;

  localparam int unsigned ALPHA = 256;
  localparam int unsigned LEN_BITS = 20;
  localparam longint unsigned REPEAT_CAP = 64'd2 << LEN_BITS;
  localparam int unsigned BUCKET_MAX = 1048576;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_WORDS = 250;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    op_e              op;
    logic             map_bit;
    logic [BYTE_W-1:0] mtf_entry;
    logic [SYM_W-1:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic [REP_W-1:0]  count;
    status_e           status;
  } run_word_t;

  // how the bucket is brought to its end
  typedef enum int {
    END_EXACT_RANKS, END_MIXED, END_EARLY, END_AT_LENGTH, END_BAD_RANK, END_SHORT_BUCKET
  } close_e;

  // DUT ports
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i = '0;
  logic               map_bit_i = 1'b0;
  logic [BYTE_W-1:0]  mtf_entry_i = '0;
  logic [SYM_W-1:0]   symbol_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [BYTE_W-1:0]  byte_value_o;
  logic [REP_W-1:0]   repeat_count_o;
  logic [STAT_W-1:0]  status_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [LEN_W-1:0]   cfg_data_i = '0;

  // decoder state mirrored by the bench
  logic [7:0]         inv_map [ALPHA];
  logic [7:0]         mtf_row [ALPHA];
  int unsigned        local_size = 0;
  int unsigned        map_pos = 0;
  int unsigned        load_pos = 0;
  int unsigned        run_pos = 0;
  int unsigned        bytes_out = 0;
  bit                 bucket_done = 1'b0;
  int unsigned        bucket_len = BUCKET_MAX;
  int unsigned        alpha_size = 256;

  // traffic bookkeeping
  in_word_t           words_to_send [$];
  run_word_t          runs_due [$];
  in_word_t           on_bus;
  bit                 word_taken = 1'b0;
  bit                 tx_steady = 1'b0;
  bit                 rx_steady = 1'b0;
  bit                 hold_req = 1'b0;
  int unsigned        gap_left = 0;
  int unsigned        stall_left = 0;
  int unsigned        hold_left = 0;
  int unsigned        fail_count = 0;
  int unsigned        cycle_count = 0;

  mtf_zero_run_bucket_decoder #(
    .ALPHABET   (ALPHA),
    .LENGTH_BITS(LEN_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .map_bit_i     (map_bit_i),
    .mtf_entry_i   (mtf_entry_i),
    .symbol_i      (symbol_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_value_o  (byte_value_o),
    .repeat_count_o(repeat_count_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Account one emitted run against the bucket length
  function automatic void tally_run(input logic [7:0] value, input longint unsigned run,
                                    output run_word_t r);
    longint unsigned total;
    longint unsigned cnt;
    total = bytes_out + run;
    cnt = run;
    if (total > bucket_len) begin
      r.status = ST_OVERRUN;
      bucket_done = 1'b1;
      if (cnt > REPEAT_CAP) cnt = REPEAT_CAP;
    end else begin
      bytes_out = total & 64'h1F_FFFF;
      if (total == bucket_len) begin
        r.status = ST_DONE;
        bucket_done = 1'b1;
      end else begin
        r.status = ST_OK;
      end
    end
    r.byte_val = value;
    r.count = cnt[REP_W-1:0];
  endfunction

  // Apply one input word; returns 1 when it yields a result word
  function automatic bit decode_word(input in_word_t w, output run_word_t r);
    longint unsigned run;
    int unsigned rank;
    int unsigned i;
    logic [7:0] pick;
    r = '0;
    case (w.op)
      OP_MAP: begin
        if (map_pos < alpha_size && map_pos < ALPHA) begin
          if (w.map_bit && local_size < ALPHA) begin
            inv_map[local_size] = map_pos[7:0];
            local_size++;
          end
          map_pos++;
        end
        return 1'b0;
      end
      OP_MTF: begin
        if (load_pos < local_size && load_pos < ALPHA) begin
          mtf_row[load_pos] = w.mtf_entry;
          load_pos++;
        end
        return 1'b0;
      end
      OP_SYM: ;
      default: return 1'b0;
    endcase
    if (bucket_done) return 1'b0;
    // end of bucket is matched ahead of the run symbols
    if (w.symbol == local_size + 1) begin
      r.status = (bytes_out == bucket_len) ? ST_DONE : ST_EARLY_END;
      bucket_done = 1'b1;
      run_pos = 0;
      return 1'b1;
    end
    if (w.symbol == SYM_RUNA || w.symbol == SYM_RUNB) begin
      run = (w.symbol == SYM_RUNA) ? (64'd1 << run_pos) : (64'd2 << run_pos);
      if (run_pos < 31) run_pos++;
      tally_run(inv_map[mtf_row[0]], run, r);
      return 1'b1;
    end
    rank = w.symbol - 1;
    if (rank >= local_size || rank >= ALPHA) begin
      r.status = ST_BAD_RANK;
      bucket_done = 1'b1;
      run_pos = 0;
      return 1'b1;
    end
    // move the picked entry to the front
    pick = mtf_row[rank];
    for (i = rank; i > 0; i--) mtf_row[i] = mtf_row[i-1];
    mtf_row[0] = pick;
    run_pos = 0;
    tally_run(inv_map[pick], 64'd1, r);
    return 1'b1;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Driver: next word goes out at a falling edge once the last one was taken and its gap ran out
  always @(negedge clk_i) begin
    if (!in_valid_i || word_taken) begin
      word_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        on_bus = words_to_send.pop_front();
        operation_i <= on_bus.op;
        map_bit_i <= on_bus.map_bit;
        mtf_entry_i <= on_bus.mtf_entry;
        symbol_i <= on_bus.symbol;
        in_valid_i <= 1'b1;
        gap_left = pick_gap(tx_steady);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap(rx_steady);
    end
  end

  // Monitor: predict on accepted input words, check accepted result words
  always @(posedge clk_i) begin
    run_word_t made;
    run_word_t want;
    if (in_valid_i && !in_stall_o) begin
      word_taken = 1'b1;
      if (decode_word(on_bus, made)) runs_due.push_back(made);
    end
    if (out_valid_o && !out_stall_i) begin
      if (runs_due.size() == 0) begin
        $error("result word with nothing expected: byte %0d count %0d status %0d",
               byte_value_o, repeat_count_o, status_o);
        fail_count++;
      end else begin
        want = runs_due.pop_front();
        if (byte_value_o !== want.byte_val) begin
          $error("byte_value: expected %0d, got %0d", want.byte_val, byte_value_o);
          fail_count++;
        end
        if (repeat_count_o !== want.count) begin
          $error("repeat_count: expected %0d, got %0d", want.count, repeat_count_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mtf_zero_run_bucket_decoder regression: fail");
      $finish;
    end
  end

  // Stimulus helpers
  function automatic in_word_t rand_word(input op_e op);
    in_word_t w;
    w.op = op;
    w.map_bit = $urandom_range(0, 1);
    w.mtf_entry = $urandom_range(0, 255);
    w.symbol = $urandom_range(0, 511);
    return w;
  endfunction

  task automatic offer_symbol(input int unsigned sym);
    in_word_t w;
    w = rand_word(OP_SYM);
    w.symbol = sym;
    words_to_send.push_back(w);
  endtask

  // Rank symbol, biased toward the front of the list
  function automatic int unsigned rank_symbol();
    int unsigned top;
    top = local_size - 1;
    if ($urandom_range(0, 99) < 60) return 1 + $urandom_range(1, (top < 3) ? top : 3);
    return 1 + $urandom_range(1, top);
  endfunction

  // A zero run of k digits closed by a rank, as a real stream would have it
  task automatic offer_group(input int unsigned k);
    repeat (k) offer_symbol($urandom_range(0, 1) ? SYM_RUNB : SYM_RUNA);
    offer_symbol(rank_symbol());
  endtask

  task automatic offer_noise();
    case ($urandom_range(0, 2))
      0: words_to_send.push_back(rand_word(OP_MAP));
      1: words_to_send.push_back(rand_word(OP_MTF));
      default: words_to_send.push_back(rand_word(OP_NONE));
    endcase
  endtask

  task automatic offer_traffic(input int unsigned count);
    int unsigned made;
    int unsigned roll;
    int unsigned k;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        k = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        offer_group(k);
        made += k + 1;
      end else if (roll < 90) begin
        offer_symbol(rank_symbol());
        made++;
      end else begin
        offer_noise();
      end
    end
  endtask

  // Wait until every word is taken and every result has come back
  task automatic settle();
    while (words_to_send.size() != 0 || in_valid_i || runs_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_BUCKET_LENGTH) bucket_len = val;
    else alpha_size = val[ASIZE_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    in_word_t w;
    int unsigned pos;
    int unsigned density;
    int unsigned limit;
    int unsigned phase;
    int unsigned n;
    close_e how;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Narrow alphabet first: only the first map bit counts
    write_reg(REG_ALPHABET_SIZE, 1);
    write_reg(REG_BUCKET_LENGTH, 1);
    w = rand_word(OP_MAP);
    w.map_bit = 1'b1;
    words_to_send.push_back(w);
    repeat (2) words_to_send.push_back(rand_word(OP_MAP));
    settle();

    // Rest of the presence map; the last value is always present
    write_reg(REG_ALPHABET_SIZE, 256);
    density = $urandom_range(0, 2);
    for (pos = 1; pos < ALPHA; pos++) begin
      w = rand_word(OP_MAP);
      case (density)
        0: w.map_bit = 1'b1;
        1: w.map_bit = ($urandom_range(0, 3) != 0);
        default: w.map_bit = ($urandom_range(0, 15) == 0);
      endcase
      if (pos == ALPHA - 1) w.map_bit = 1'b1;
      words_to_send.push_back(w);
      if ($urandom_range(0, 19) == 0) words_to_send.push_back(rand_word(OP_NONE));
    end
    repeat (3) words_to_send.push_back(rand_word(OP_MAP));
    settle();

    // Initial MTF list in local codes, then entries past the end
    for (pos = 0; pos < local_size; pos++) begin
      w = rand_word(OP_MTF);
      w.mtf_entry = $urandom_range(0, local_size - 1);
      words_to_send.push_back(w);
      if ($urandom_range(0, 19) == 0) offer_noise();
    end
    w = rand_word(OP_MTF);
    w.mtf_entry = 8'hFF;
    words_to_send.push_back(w);
    w.mtf_entry = 8'h00;
    words_to_send.push_back(w);
    settle();

    // Directed symbols: run digits, lowest and last rank, ignored words, long run
    write_reg(REG_BUCKET_LENGTH, BUCKET_MAX);
    offer_symbol(SYM_RUNA);
    offer_symbol(SYM_RUNB);
    offer_symbol(SYM_RUNA);
    offer_symbol(2);
    offer_symbol(local_size);
    offer_symbol(SYM_RUNB);
    offer_symbol(local_size);
    w = rand_word(OP_NONE);
    w.symbol = 9'h1FF;
    w.mtf_entry = 8'hFF;
    w.map_bit = 1'b1;
    words_to_send.push_back(w);
    words_to_send.push_back(rand_word(OP_MAP));
    words_to_send.push_back(rand_word(OP_MTF));
    offer_symbol(2);
    repeat (12) offer_symbol(SYM_RUNA);
    offer_symbol(2);
    settle();

    // Random phases, each with its own register settings and idling style
    for (phase = 0; phase < 4; phase++) begin
      if (phase == 0) begin
        write_reg(REG_BUCKET_LENGTH, BUCKET_MAX);
      end else begin
        limit = bytes_out + 100000 + $urandom_range(0, 400000);
        write_reg(REG_BUCKET_LENGTH, (limit > BUCKET_MAX) ? BUCKET_MAX : limit);
      end
      write_reg(REG_ALPHABET_SIZE, (phase == 3) ? 1 : $urandom_range(1, 256));
      tx_steady = (phase == 1 || phase == 2);
      rx_steady = (phase == 2);
      offer_traffic(PHASE_WORDS);
      // receiver holds off while the sender keeps offering words
      if (phase == 1) hold_req = 1'b1;
      settle();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // Close the bucket in one of the ways it can end
    how = close_e'($urandom_range(0, 5));
    case (how)
      END_EXACT_RANKS: begin
        n = $urandom_range(1, 30);
        write_reg(REG_BUCKET_LENGTH, bytes_out + n);
        repeat (n) offer_symbol(rank_symbol());
      end
      END_MIXED: begin
        write_reg(REG_BUCKET_LENGTH, bytes_out + $urandom_range(1, 40));
        while (!bucket_done) begin
          offer_group($urandom_range(0, 3));
          settle();
        end
      end
      END_EARLY: offer_symbol(local_size + 1);
      END_AT_LENGTH: begin
        write_reg(REG_BUCKET_LENGTH, bytes_out);
        offer_symbol(local_size + 1);
      end
      END_BAD_RANK: offer_symbol($urandom_range(local_size + 2, 511));
      default: begin
        write_reg(REG_BUCKET_LENGTH, 1);
        offer_symbol(SYM_RUNA);
      end
    endcase
    settle();

    // Once finished, nothing more comes out
    repeat (10) words_to_send.push_back(rand_word(op_e'($urandom_range(0, 3))));
    settle();

    if (fail_count == 0) begin
      $display("mtf_zero_run_bucket_decoder regression: pass");
    end else begin
      $display("mtf_zero_run_bucket_decoder regression: fail");
    end
    $finish;
  end

endmodule
